@@ src/pcp_pkg.sv @@
// shared types and constants for the pwm channel command parser
// no dependencies; compile before the interfaces and modules
`default_nettype none

package pcp_pkg;

	// character codes seen by the parser (7-bit, after masking)
	localparam logic [6:0] CH_NUL = 7'h00;
	localparam logic [6:0] CH_NL  = 7'h0A;
	localparam logic [6:0] CH_CR  = 7'h0D;
	localparam logic [6:0] CH_SP  = 7'h20;
	localparam logic [6:0] CH_0   = 7'h30;
	localparam logic [6:0] CH_1   = 7'h31;
	localparam logic [6:0] CH_6   = 7'h36;
	localparam logic [6:0] CH_9   = 7'h39;

	// characters kept per field, 1..31
	localparam logic [4:0] MAX_FIELD_CHARS = 5'd20;

	// field counter codes
	localparam logic [1:0] FIELD_CMD   = 2'd0;
	localparam logic [1:0] FIELD_VALUE = 2'd1;
	localparam logic [1:0] FIELD_EXTRA = 2'd2;

	localparam logic [4:0] CMD_LEN_MAX = 5'd31;

	typedef struct packed {
		logic [6:0]  echo_char;
		logic        write_valid;
		logic [2:0]  write_channel;
		logic [15:0] write_value;
	} result_t;

endpackage

`default_nettype wire

@@ src/pcp_rx_if.sv @@
// receive channel: one serial byte per word
// depends on nothing
`default_nettype none

interface pcp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ src/pcp_res_if.sv @@
// result channel: echo character and optional duty write per word
// depends on nothing
`default_nettype none

interface pcp_res_if;
	logic        valid;
	logic        ready;
	logic [6:0]  echo_char;
	logic        write_valid;
	logic [2:0]  write_channel;
	logic [15:0] write_value;

	modport source (output valid, output echo_char, output write_valid,
		output write_channel, output write_value, input ready);
	modport sink (input valid, input echo_char, input write_valid,
		input write_channel, input write_value, output ready);
endinterface

`default_nettype wire

@@ src/pwm_channel_command_parser_top.sv @@
// Duty command line parser. Every received word yields exactly one result word, via
// the input register and the result register: the masked echo character plus, on the
// newline that ends a well-formed "N value" line (N = '1'..'6', value all digits,
// wrapping at 65536), a duty write for channel N-1. A new byte is taken every cycle
// while no result is held back; the parser state is one short update per character
// between the two registers; while a result waits, an empty input register takes one.
// depends on pcp_pkg, pcp_rx_if, pcp_res_if, pcp_parser_core
`default_nettype none

module pwm_channel_command_parser_top (
	input  wire logic clk,
	input  wire logic arst_n,
	pcp_rx_if.sink    rx,
	pcp_res_if.source res
);

	logic             valid_s1;
	logic [6:0]       ch_s1;
	logic             res_valid_q;
	pcp_pkg::result_t res_q;
	pcp_pkg::result_t core_res;
	logic             advance;
	logic             step;

	assign advance  = !res_valid_q || res.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			ch_s1 <= rx.rx_byte[6:0];
		end
	end

	pcp_parser_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= core_res;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.echo_char     = res_q.echo_char;
	assign res.write_valid   = res_q.write_valid;
	assign res.write_channel = res_q.write_channel;
	assign res.write_value   = res_q.write_value;

`ifndef ASSERT_OFF
	// a write only names one of the six channels
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.write_valid |-> res_q.write_channel <= 3'd5)
		else $error("write channel out of range");

	// no write means zero channel and value
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.write_valid |->
		res_q.write_channel == 3'd0 && res_q.write_value == 16'd0)
		else $error("idle write fields not zero");

	// an empty result register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> rx.ready)
		else $error("input stalled with empty output");

	// a held word in stage one keeps its character
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(ch_s1))
		else $error("stage one word lost while stalled");
`endif

endmodule

`default_nettype wire

@@ src/pcp_parser_core.sv @@
// line parser state and next-state logic, one character per step
// depends on pcp_pkg
`default_nettype none

module pcp_parser_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [6:0]      ch,
	output pcp_pkg::result_t     res
);

	logic [1:0]  field_part_q, field_part_d;
	logic [4:0]  char_index_q, char_index_d;
	logic [6:0]  cmd_first_char_q, cmd_first_char_d;
	logic [4:0]  cmd_length_q, cmd_length_d;
	logic [15:0] value_accum_q, value_accum_d;
	logic        value_all_digits_q, value_all_digits_d;
	logic        cmd_ended_q, cmd_ended_d;
	logic        value_ended_q, value_ended_d;

	logic        is_digit;
	logic [6:0]  digit_full;
	logic [6:0]  chan_full;
	logic [15:0] accum_x10;

	assign is_digit   = (ch >= pcp_pkg::CH_0) && (ch <= pcp_pkg::CH_9);
	assign digit_full = ch - pcp_pkg::CH_0;
	assign chan_full  = cmd_first_char_q - pcp_pkg::CH_1;
	// times ten as two shifts and an add, wrapping at 16 bits
	assign accum_x10  = {value_accum_q[12:0], 3'b000} + {value_accum_q[14:0], 1'b0};

	always_comb begin
		field_part_d       = field_part_q;
		char_index_d       = char_index_q;
		cmd_first_char_d   = cmd_first_char_q;
		cmd_length_d       = cmd_length_q;
		value_accum_d      = value_accum_q;
		value_all_digits_d = value_all_digits_q;
		cmd_ended_d        = cmd_ended_q;
		value_ended_d      = value_ended_q;

		res.echo_char     = ch;
		res.write_valid   = 1'b0;
		res.write_channel = 3'd0;
		res.write_value   = 16'd0;

		case (ch)
			pcp_pkg::CH_NL: begin
				if (field_part_q == pcp_pkg::FIELD_VALUE && cmd_length_q == 5'd1 &&
						cmd_first_char_q >= pcp_pkg::CH_1 &&
						cmd_first_char_q <= pcp_pkg::CH_6 && value_all_digits_q) begin
					res.write_valid   = 1'b1;
					res.write_channel = chan_full[2:0];
					res.write_value   = value_accum_q;
				end
				field_part_d       = pcp_pkg::FIELD_CMD;
				char_index_d       = 5'd0;
				cmd_first_char_d   = 7'd0;
				cmd_length_d       = 5'd0;
				cmd_ended_d        = 1'b0;
				value_accum_d      = 16'd0;
				value_all_digits_d = 1'b1;
				value_ended_d      = 1'b0;
			end
			pcp_pkg::CH_SP: begin
				if (field_part_q != pcp_pkg::FIELD_EXTRA) begin
					field_part_d = field_part_q + 2'd1;
				end
				char_index_d       = 5'd0;
				value_accum_d      = 16'd0;
				value_all_digits_d = 1'b1;
				value_ended_d      = 1'b0;
			end
			pcp_pkg::CH_CR: begin
			end
			default: begin
				if (char_index_q < pcp_pkg::MAX_FIELD_CHARS) begin
					if (field_part_q == pcp_pkg::FIELD_CMD) begin
						char_index_d = char_index_q + 5'd1;
						if (!cmd_ended_q) begin
							if (ch == pcp_pkg::CH_NUL) begin
								cmd_ended_d = 1'b1;
							end else begin
								if (cmd_length_q == 5'd0) begin
									cmd_first_char_d = ch;
								end
								if (cmd_length_q != pcp_pkg::CMD_LEN_MAX) begin
									cmd_length_d = cmd_length_q + 5'd1;
								end
							end
						end
					end else if (field_part_q == pcp_pkg::FIELD_VALUE) begin
						char_index_d = char_index_q + 5'd1;
						if (!value_ended_q) begin
							if (ch == pcp_pkg::CH_NUL) begin
								value_ended_d = 1'b1;
							end else if (is_digit) begin
								value_accum_d = accum_x10 + {12'd0, digit_full[3:0]};
							end else begin
								value_all_digits_d = 1'b0;
							end
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_part_q       <= pcp_pkg::FIELD_CMD;
			char_index_q       <= 5'd0;
			cmd_first_char_q   <= 7'd0;
			cmd_length_q       <= 5'd0;
			value_accum_q      <= 16'd0;
			value_all_digits_q <= 1'b1;
			cmd_ended_q        <= 1'b0;
			value_ended_q      <= 1'b0;
		end else if (step) begin
			field_part_q       <= field_part_d;
			char_index_q       <= char_index_d;
			cmd_first_char_q   <= cmd_first_char_d;
			cmd_length_q       <= cmd_length_d;
			value_accum_q      <= value_accum_d;
			value_all_digits_q <= value_all_digits_d;
			cmd_ended_q        <= cmd_ended_d;
			value_ended_q      <= value_ended_d;
		end
	end

endmodule

`default_nettype wire
